// ===== hdl/tft_pkg.sv =====
package tft_pkg;

   // location counter width (saturating)
   localparam int LocBits = 16;

   localparam logic [3:0] StStart    = 4'd0;
   localparam logic [3:0] StName     = 4'd1;
   localparam logic [3:0] StTagBegin = 4'd2;
   localparam logic [3:0] StTag      = 4'd3;
   localparam logic [3:0] StClass    = 4'd4;
   localparam logic [3:0] StOr       = 4'd5;
   localparam logic [3:0] StAnd      = 4'd6;
   localparam logic [3:0] StQuad     = 4'd7;
   localparam logic [3:0] StStar     = 4'd8;

   localparam logic [3:0] TkName   = 4'd0;
   localparam logic [3:0] TkTag    = 4'd1;
   localparam logic [3:0] TkClass  = 4'd2;
   localparam logic [3:0] TkNot    = 4'd3;
   localparam logic [3:0] TkAnd    = 4'd4;
   localparam logic [3:0] TkOr     = 4'd5;
   localparam logic [3:0] TkLeft   = 4'd6;
   localparam logic [3:0] TkRight  = 4'd7;
   localparam logic [3:0] TkQuad   = 4'd8;
   localparam logic [3:0] TkStar   = 4'd9;
   localparam logic [3:0] TkDouble = 4'd10;
   localparam logic [3:0] TkLBrack = 4'd11;
   localparam logic [3:0] TkRBrack = 4'd12;
   localparam logic [3:0] TkEnd    = 4'd13;
   localparam logic [3:0] TkNone   = 4'd15;

   localparam logic [1:0] KindValue    = 2'd0;
   localparam logic [1:0] KindToken    = 2'd1;
   localparam logic [1:0] KindBadChar  = 2'd2;
   localparam logic [1:0] KindEarlyEnd = 2'd3;

   localparam logic [7:0] ChHash   = 8'h23;
   localparam logic [7:0] ChLt     = 8'h3C;
   localparam logic [7:0] ChGt     = 8'h3E;
   localparam logic [7:0] ChBar    = 8'h7C;
   localparam logic [7:0] ChAmp    = 8'h26;
   localparam logic [7:0] ChColon  = 8'h3A;
   localparam logic [7:0] ChStar   = 8'h2A;
   localparam logic [7:0] ChLBrack = 8'h5B;
   localparam logic [7:0] ChRBrack = 8'h5D;
   localparam logic [7:0] ChBang   = 8'h21;
   localparam logic [7:0] ChLParen = 8'h28;
   localparam logic [7:0] ChRParen = 8'h29;
   localparam logic [7:0] ChUnder  = 8'h5F;
   localparam logic [7:0] ChDash   = 8'h2D;
   localparam logic [7:0] ChDot    = 8'h2E;

   typedef struct packed {
      logic [7:0] ch;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  token_type;
      logic [7:0]  value_char;
      logic [15:0] location;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } lex_out_type;

   typedef struct packed {
      logic restart;
      logic at_start;
      logic cnt_zero;
   } lex_stat_type;

   typedef struct packed {
      logic [2:0] level;
      logic       room;
   } fifo_stat_type;

endpackage

// ===== hdl/tft_lexer.sv =====
module tft_lexer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  tft_pkg::req_type      item,
   output tft_pkg::lex_out_type  push,
   output tft_pkg::lex_stat_type stat
);

   typedef struct packed {
      logic       ok;
      logic [3:0] next;
      logic [3:0] prep;
   } follow_type;

   localparam logic [tft_pkg::LocBits-1:0] LocMax = {tft_pkg::LocBits{1'b1}};

   logic [3:0]                 st_ff, st_in, st_next;
   logic [tft_pkg::LocBits-1:0] cnt_ff, cnt_in, cnt_inc;
   logic                       restart;
   logic [15:0]                loc;
   logic [7:0]                 c;
   logic                       eot;
   logic [3:0]                 tok;
   follow_type                 fw;
   tft_pkg::rsp_type           r0, r1;
   logic [1:0]                 n;

   function automatic logic is_space(input logic [7:0] x);
      return (x == 8'h20) || (x >= 8'h09 && x <= 8'h0D);
   endfunction

   function automatic logic is_alpha(input logic [7:0] x);
      return (x >= 8'h41 && x <= 8'h5A) || (x >= 8'h61 && x <= 8'h7A);
   endfunction

   function automatic logic is_alnum(input logic [7:0] x);
      return is_alpha(x) || (x >= 8'h30 && x <= 8'h39);
   endfunction

   function automatic logic [3:0] single_tok(input logic [7:0] x);
      logic [3:0] t;
      case (x)
         tft_pkg::ChBang:   t = tft_pkg::TkNot;
         tft_pkg::ChLParen: t = tft_pkg::TkLeft;
         tft_pkg::ChRParen: t = tft_pkg::TkRight;
         tft_pkg::ChLBrack: t = tft_pkg::TkLBrack;
         tft_pkg::ChRBrack: t = tft_pkg::TkRBrack;
         default:           t = tft_pkg::TkNone;
      endcase
      return t;
   endfunction

   // character that closes a name, tag or star
   function automatic follow_type follow(input logic [7:0] x);
      follow_type f;
      f.ok   = 1'b1;
      f.next = tft_pkg::StStart;
      f.prep = tft_pkg::TkNone;
      if (!is_space(x)) begin
         case (x)
            tft_pkg::ChHash:  f.next = tft_pkg::StTagBegin;
            tft_pkg::ChLt:    f.next = tft_pkg::StClass;
            tft_pkg::ChBar:   f.next = tft_pkg::StOr;
            tft_pkg::ChAmp:   f.next = tft_pkg::StAnd;
            tft_pkg::ChColon: f.next = tft_pkg::StQuad;
            tft_pkg::ChStar:  f.next = tft_pkg::StStar;
            default: begin
               f.prep = single_tok(x);
               f.ok   = (f.prep != tft_pkg::TkNone);
            end
         endcase
      end
      return f;
   endfunction

   function automatic tft_pkg::rsp_type mk(input logic [1:0] k, input logic [3:0] t,
                                           input logic [7:0] v, input logic [15:0] l);
      tft_pkg::rsp_type r;
      r.kind       = k;
      r.token_type = t;
      r.value_char = v;
      r.location   = l;
      r.last       = 1'b0;
      return r;
   endfunction

   always_comb begin
      cnt_inc = (cnt_ff == LocMax) ? cnt_ff : cnt_ff + 1'b1;
      loc     = 16'(cnt_inc);
      c       = item.ch;
      eot     = item.end_of_text;
      fw      = follow(c);
      r0      = '0;
      r1      = '0;
      n       = 2'd0;
      st_next = st_ff;
      restart = 1'b0;
      tok     = (st_ff == tft_pkg::StName) ? tft_pkg::TkName :
                (st_ff == tft_pkg::StTag)  ? tft_pkg::TkTag  : tft_pkg::TkStar;
      case (st_ff)
         tft_pkg::StName, tft_pkg::StTag, tft_pkg::StStar: begin
            if (eot) begin
               r0 = mk(tft_pkg::KindToken, tok, 8'd0, loc);
               r1 = mk(tft_pkg::KindToken, tft_pkg::TkEnd, 8'd0, loc);
               n = 2'd2;
               restart = 1'b1;
            end else if (st_ff == tft_pkg::StName && (is_alnum(c) || c == tft_pkg::ChUnder)) begin
               r0 = mk(tft_pkg::KindValue, tft_pkg::TkName, c, loc);
               n = 2'd1;
            end else if (st_ff == tft_pkg::StTag && (is_alnum(c) || c == tft_pkg::ChUnder
                         || c == tft_pkg::ChDash || c == tft_pkg::ChDot)) begin
               r0 = mk(tft_pkg::KindValue, tft_pkg::TkTag, c, loc);
               n = 2'd1;
            end else if (st_ff == tft_pkg::StStar && c == tft_pkg::ChStar) begin
               r0 = mk(tft_pkg::KindToken, tft_pkg::TkDouble, 8'd0, loc);
               n = 2'd1;
               st_next = tft_pkg::StStart;
            end else if (st_ff == tft_pkg::StStar && (is_alpha(c) || c == tft_pkg::ChUnder)) begin
               r0 = mk(tft_pkg::KindToken, tft_pkg::TkStar, 8'd0, loc);
               r1 = mk(tft_pkg::KindValue, tft_pkg::TkName, c, loc);
               n = 2'd2;
               st_next = tft_pkg::StName;
            end else if (fw.ok) begin
               r0 = mk(tft_pkg::KindToken, tok, 8'd0, loc);
               r1 = mk(tft_pkg::KindToken, fw.prep, 8'd0, loc);
               n = (fw.prep != tft_pkg::TkNone) ? 2'd2 : 2'd1;
               st_next = fw.next;
            end else begin
               r0 = mk(tft_pkg::KindBadChar, 4'd0, c, loc);
               n = 2'd1;
               restart = 1'b1;
            end
         end
         tft_pkg::StTagBegin, tft_pkg::StClass, tft_pkg::StOr, tft_pkg::StAnd,
         tft_pkg::StQuad: begin
            n = 2'd1;
            if (eot) begin
               r0 = mk(tft_pkg::KindEarlyEnd, 4'd0, 8'd0, loc);
               restart = 1'b1;
            end else if (st_ff == tft_pkg::StTagBegin && is_alpha(c)) begin
               r0 = mk(tft_pkg::KindValue, tft_pkg::TkTag, c, loc);
               st_next = tft_pkg::StTag;
            end else if (st_ff == tft_pkg::StClass && is_alpha(c)) begin
               r0 = mk(tft_pkg::KindValue, tft_pkg::TkClass, c, loc);
            end else if (st_ff == tft_pkg::StClass && c == tft_pkg::ChGt) begin
               r0 = mk(tft_pkg::KindToken, tft_pkg::TkClass, 8'd0, loc);
               st_next = tft_pkg::StStart;
            end else if (st_ff == tft_pkg::StOr && c == tft_pkg::ChBar) begin
               r0 = mk(tft_pkg::KindToken, tft_pkg::TkOr, 8'd0, loc);
               st_next = tft_pkg::StStart;
            end else if (st_ff == tft_pkg::StAnd && c == tft_pkg::ChAmp) begin
               r0 = mk(tft_pkg::KindToken, tft_pkg::TkAnd, 8'd0, loc);
               st_next = tft_pkg::StStart;
            end else if (st_ff == tft_pkg::StQuad && c == tft_pkg::ChColon) begin
               r0 = mk(tft_pkg::KindToken, tft_pkg::TkQuad, 8'd0, loc);
               st_next = tft_pkg::StStart;
            end else begin
               r0 = mk(tft_pkg::KindBadChar, 4'd0, c, loc);
               restart = 1'b1;
            end
         end
         default: begin
            // start state; unused codes behave the same
            st_next = tft_pkg::StStart;
            if (eot) begin
               r0 = mk(tft_pkg::KindToken, tft_pkg::TkEnd, 8'd0, loc);
               n = 2'd1;
               restart = 1'b1;
            end else if (is_space(c)) begin
               st_next = tft_pkg::StStart;
            end else if (is_alpha(c) || c == tft_pkg::ChUnder) begin
               r0 = mk(tft_pkg::KindValue, tft_pkg::TkName, c, loc);
               n = 2'd1;
               st_next = tft_pkg::StName;
            end else if (c == tft_pkg::ChHash) begin
               // no leading-alpha check straight from start
               st_next = tft_pkg::StTag;
            end else if (c == tft_pkg::ChLt) begin
               st_next = tft_pkg::StClass;
            end else if (c == tft_pkg::ChBar) begin
               st_next = tft_pkg::StOr;
            end else if (c == tft_pkg::ChAmp) begin
               st_next = tft_pkg::StAnd;
            end else if (c == tft_pkg::ChColon) begin
               st_next = tft_pkg::StQuad;
            end else if (c == tft_pkg::ChStar) begin
               st_next = tft_pkg::StStar;
            end else if (single_tok(c) != tft_pkg::TkNone) begin
               r0 = mk(tft_pkg::KindToken, single_tok(c), 8'd0, loc);
               n = 2'd1;
            end else begin
               r0 = mk(tft_pkg::KindBadChar, 4'd0, c, loc);
               n = 2'd1;
               restart = 1'b1;
            end
         end
      endcase
      r0.last = (n == 2'd1);
      r1.last = (n == 2'd2);

      st_in  = st_ff;
      cnt_in = cnt_ff;
      if (adv) begin
         st_in  = restart ? tft_pkg::StStart : st_next;
         cnt_in = restart ? '0 : cnt_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= tft_pkg::StStart;
         cnt_ff <= '0;
      end else begin
         st_ff  <= st_in;
         cnt_ff <= cnt_in;
      end
   end

   assign push.count    = n;
   assign push.first    = r0;
   assign push.second   = r1;
   assign stat.restart  = restart;
   assign stat.at_start = (st_ff == tft_pkg::StStart);
   assign stat.cnt_zero = (cnt_ff == '0);

endmodule

// ===== hdl/tft_rsp_fifo.sv =====
module tft_rsp_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_en,
   input  tft_pkg::lex_out_type   push,
   input  logic                   pop_stall,
   output logic                   out_valid,
   output tft_pkg::rsp_type       out_data,
   output tft_pkg::fifo_stat_type stat
);

   tft_pkg::rsp_type mem [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [2:0] level_ff, level_in;
   logic [1:0] n;
   logic       pop;

   always_comb begin
      n         = push_en ? push.count : 2'd0;
      pop       = out_valid && !pop_stall;
      wr_ptr_in = wr_ptr_ff + n;
      rd_ptr_in = rd_ptr_ff + {1'b0, pop};
      level_in  = level_ff + {1'b0, n} - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (n != 2'd0) begin
         mem[wr_ptr_ff] <= push.first;
      end
      if (n == 2'd2) begin
         mem[wr_ptr_ff + 2'd1] <= push.second;
      end
   end

   assign out_valid  = (level_ff != 3'd0);
   assign out_data   = mem[rd_ptr_ff];
   assign stat.level = level_ff;
   assign stat.room  = (level_ff <= 3'd2);

endmodule

// ===== hdl/tag_filter_tokenizer.sv =====
// A taken req beat goes through the input register and the result queue to rsp.
// Throughput: one character per cycle; the four-entry result queue absorbs the
// second result of a two-result character and stalls req when fewer than two slots are free.
// Reset (synchronous, active high): lexer back to start, location count zero,
// input register and result queue emptied.
module tag_filter_tokenizer (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tft_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tft_pkg::rsp_type rsp_payload
);

   logic                   in_vld_ff, in_vld_in;
   tft_pkg::req_type       in_data_ff;
   logic                   adv;
   logic                   req_take;
   tft_pkg::lex_out_type   push;
   tft_pkg::lex_stat_type  lex_stat;
   tft_pkg::fifo_stat_type fifo_stat;

   assign adv       = in_vld_ff && fifo_stat.room;
   assign req_stall = in_vld_ff && !adv;
   assign req_take  = req_valid && !req_stall;
   assign in_vld_in = req_take || (in_vld_ff && !adv);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_payload;
      end
   end

   tft_lexer u_lexer (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .item  (in_data_ff),
      .push  (push),
      .stat  (lex_stat)
   );

   tft_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_en   (adv),
      .push      (push),
      .pop_stall (rsp_stall),
      .out_valid (rsp_valid),
      .out_data  (rsp_payload),
      .stat      (fifo_stat)
   );

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      fifo_stat.level <= 3'd4)
      else $error("result queue overflow");

   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      adv && lex_stat.restart |=> lex_stat.at_start && lex_stat.cnt_zero)
      else $error("lexer not back at start after end or error");

   a_push_shows: assert property (@(posedge clock) disable iff (reset)
      adv && push.count != 2'd0 |=> rsp_valid)
      else $error("pushed result not presented");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      req_take |-> !in_vld_ff || adv)
      else $error("input register overwritten while held");

endmodule

// ===== dv/tag_filter_tokenizer_tb.sv =====
module tag_filter_tokenizer_tb;

   localparam int RandomChars = 1620;
   localparam int CycleLimit  = 3_000_000;
   localparam int LongHold    = 80;

   typedef struct {
      tft_pkg::req_type beat;
      bit               drain;   // hold this beat until every pending result is back
   } text_item_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   tft_pkg::req_type req_payload = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   tft_pkg::rsp_type rsp_payload;

   text_item_type    text_q[$];
   tft_pkg::rsp_type lexeme_q[$];
   tft_pkg::rsp_type step_out[$];

   logic [3:0]                  lex_st = tft_pkg::StStart;
   logic [tft_pkg::LocBits-1:0] loc_count = '0;

   bit req_taken = 1'b0;
   bit drain_next = 1'b0;
   int send_gap = 0;
   int stall_left = 0;
   bit hold_done = 1'b0;
   int hold_at = 0;
   int taken_count = 0;
   int errors = 0;
   int cycles = 0;

   tag_filter_tokenizer dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------- character classes (ASCII, C locale)
   function automatic bit is_blank(logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic bit is_letter(logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   function automatic bit is_word(logic [7:0] c);
      return is_letter(c) || (c >= "0" && c <= "9") || c == tft_pkg::ChUnder;
   endfunction

   function automatic logic [3:0] single_tok(logic [7:0] c);
      case (c)
         tft_pkg::ChBang:   return tft_pkg::TkNot;
         tft_pkg::ChLParen: return tft_pkg::TkLeft;
         tft_pkg::ChRParen: return tft_pkg::TkRight;
         tft_pkg::ChLBrack: return tft_pkg::TkLBrack;
         tft_pkg::ChRBrack: return tft_pkg::TkRBrack;
         default:           return tft_pkg::TkNone;
      endcase
   endfunction

   // character that closes a name, tag or star; 0 if it is not allowed there
   function automatic bit closing_char(input logic [7:0] c, output logic [3:0] nxt,
                                       output logic [3:0] extra);
      nxt = tft_pkg::StStart;
      extra = tft_pkg::TkNone;
      if (is_blank(c)) return 1'b1;
      case (c)
         tft_pkg::ChHash:  nxt = tft_pkg::StTagBegin;
         tft_pkg::ChLt:    nxt = tft_pkg::StClass;
         tft_pkg::ChBar:   nxt = tft_pkg::StOr;
         tft_pkg::ChAmp:   nxt = tft_pkg::StAnd;
         tft_pkg::ChColon: nxt = tft_pkg::StQuad;
         tft_pkg::ChStar:  nxt = tft_pkg::StStar;
         default: begin
            extra = single_tok(c);
            return extra != tft_pkg::TkNone;
         end
      endcase
      return 1'b1;
   endfunction

   function automatic void emit(logic [1:0] k, logic [3:0] t, logic [7:0] v);
      tft_pkg::rsp_type r;
      r.kind = k;
      r.token_type = t;
      r.value_char = v;
      r.location = loc_count[15:0];
      r.last = 1'b0;
      step_out = {step_out, r};
   endfunction

   // ---------------- lexer prediction for one accepted beat
   function automatic void lex_char(tft_pkg::req_type b);
      logic [7:0] c;
      logic [3:0] st, tok, nxt, extra;
      bit restart;
      c = b.ch;
      st = lex_st;
      restart = 1'b0;
      step_out = {};
      if (loc_count != '1) loc_count++;
      case (st)
         tft_pkg::StName, tft_pkg::StTag, tft_pkg::StStar: begin
            tok = (st == tft_pkg::StName) ? tft_pkg::TkName :
                  (st == tft_pkg::StTag) ? tft_pkg::TkTag : tft_pkg::TkStar;
            if (b.end_of_text) begin
               emit(tft_pkg::KindToken, tok, 8'h00);
               emit(tft_pkg::KindToken, tft_pkg::TkEnd, 8'h00);
               restart = 1'b1;
            end else if (st == tft_pkg::StName && is_word(c)) begin
               emit(tft_pkg::KindValue, tft_pkg::TkName, c);
            end else if (st == tft_pkg::StTag && (is_word(c) || c == tft_pkg::ChDash
                         || c == tft_pkg::ChDot)) begin
               emit(tft_pkg::KindValue, tft_pkg::TkTag, c);
            end else if (st == tft_pkg::StStar && c == tft_pkg::ChStar) begin
               emit(tft_pkg::KindToken, tft_pkg::TkDouble, 8'h00);
               lex_st = tft_pkg::StStart;
            end else if (st == tft_pkg::StStar && (is_letter(c) || c == tft_pkg::ChUnder)) begin
               emit(tft_pkg::KindToken, tft_pkg::TkStar, 8'h00);
               emit(tft_pkg::KindValue, tft_pkg::TkName, c);
               lex_st = tft_pkg::StName;
            end else if (!closing_char(c, nxt, extra)) begin
               emit(tft_pkg::KindBadChar, tft_pkg::TkName, c);
               restart = 1'b1;
            end else begin
               emit(tft_pkg::KindToken, tok, 8'h00);
               if (extra != tft_pkg::TkNone) emit(tft_pkg::KindToken, extra, 8'h00);
               lex_st = nxt;
            end
         end
         tft_pkg::StTagBegin, tft_pkg::StClass, tft_pkg::StOr, tft_pkg::StAnd,
         tft_pkg::StQuad: begin
            if (b.end_of_text) begin
               emit(tft_pkg::KindEarlyEnd, tft_pkg::TkName, 8'h00);
               restart = 1'b1;
            end else if (st == tft_pkg::StTagBegin && is_letter(c)) begin
               emit(tft_pkg::KindValue, tft_pkg::TkTag, c);
               lex_st = tft_pkg::StTag;
            end else if (st == tft_pkg::StClass && is_letter(c)) begin
               emit(tft_pkg::KindValue, tft_pkg::TkClass, c);
            end else if (st == tft_pkg::StClass && c == tft_pkg::ChGt) begin
               emit(tft_pkg::KindToken, tft_pkg::TkClass, 8'h00);
               lex_st = tft_pkg::StStart;
            end else if (st == tft_pkg::StOr && c == tft_pkg::ChBar) begin
               emit(tft_pkg::KindToken, tft_pkg::TkOr, 8'h00);
               lex_st = tft_pkg::StStart;
            end else if (st == tft_pkg::StAnd && c == tft_pkg::ChAmp) begin
               emit(tft_pkg::KindToken, tft_pkg::TkAnd, 8'h00);
               lex_st = tft_pkg::StStart;
            end else if (st == tft_pkg::StQuad && c == tft_pkg::ChColon) begin
               emit(tft_pkg::KindToken, tft_pkg::TkQuad, 8'h00);
               lex_st = tft_pkg::StStart;
            end else begin
               emit(tft_pkg::KindBadChar, tft_pkg::TkName, c);
               restart = 1'b1;
            end
         end
         default: begin
            if (b.end_of_text) begin
               emit(tft_pkg::KindToken, tft_pkg::TkEnd, 8'h00);
               restart = 1'b1;
            end else if (is_blank(c)) begin
               lex_st = tft_pkg::StStart;
            end else if (is_letter(c) || c == tft_pkg::ChUnder) begin
               emit(tft_pkg::KindValue, tft_pkg::TkName, c);
               lex_st = tft_pkg::StName;
            end else begin
               case (c)
                  tft_pkg::ChHash:  lex_st = tft_pkg::StTag;   // no letter check at expression start
                  tft_pkg::ChLt:    lex_st = tft_pkg::StClass;
                  tft_pkg::ChBar:   lex_st = tft_pkg::StOr;
                  tft_pkg::ChAmp:   lex_st = tft_pkg::StAnd;
                  tft_pkg::ChColon: lex_st = tft_pkg::StQuad;
                  tft_pkg::ChStar:  lex_st = tft_pkg::StStar;
                  default: begin
                     tok = single_tok(c);
                     if (tok != tft_pkg::TkNone) begin
                        emit(tft_pkg::KindToken, tok, 8'h00);
                        lex_st = tft_pkg::StStart;
                     end else begin
                        emit(tft_pkg::KindBadChar, tft_pkg::TkName, c);
                        restart = 1'b1;
                     end
                  end
               endcase
            end
         end
      endcase
      if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
      foreach (step_out[i]) lexeme_q = {lexeme_q, step_out[i]};
      if (restart) begin
         lex_st = tft_pkg::StStart;
         loc_count = '0;
      end
   endfunction

   function automatic void check_field(string fname, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", fname, want, got);
         errors++;
      end
   endfunction

   // ---------------- stimulus helpers
   function automatic void add_char(logic [7:0] c, bit eot);
      text_item_type t;
      t.beat.ch = c;
      t.beat.end_of_text = eot;
      t.drain = drain_next;
      drain_next = 1'b0;
      text_q = {text_q, t};
   endfunction

   function automatic logic [7:0] rand_letter();
      return $urandom_range(0, 1) ? 8'($urandom_range("A", "Z"))
                                  : 8'($urandom_range("a", "z"));
   endfunction

   function automatic logic [7:0] rand_word();
      case ($urandom_range(0, 3))
         0: return 8'($urandom_range("0", "9"));
         1: return tft_pkg::ChUnder;
         default: return rand_letter();
      endcase
   endfunction

   // ---------------- driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (text_q.size() > 150 && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(0, 3);
            req_valid <= 1'b0;
         end else if (text_q.size() > 0 && !(text_q[0].drain && lexeme_q.size() > 0)) begin
            req_payload <= text_q[0].beat;
            req_valid <= 1'b1;
            text_q.delete(0);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------- receiver
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (!hold_done && taken_count >= hold_at) begin
            hold_done = 1'b1;
            stall_left = LongHold;
         end else if (stall_left == 0 && text_q.size() > 150 && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 4);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ---------------- monitor: predict on req beats, check rsp beats
   always @(posedge clock) begin
      tft_pkg::rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            lex_char(req_payload);
            taken_count++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (lexeme_q.size() == 0) begin
               $error("result with nothing pending: %p", rsp_payload);
               errors++;
            end else begin
               want = lexeme_q.pop_front();
               check_field("kind", want.kind, rsp_payload.kind);
               check_field("token_type", want.token_type, rsp_payload.token_type);
               check_field("value_char", want.value_char, rsp_payload.value_char);
               check_field("location", want.location, rsp_payload.location);
               check_field("last", want.last, rsp_payload.last);
            end
         end
      end
      req_taken <= !reset && req_valid && !req_stall;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CycleLimit) begin
         $display("status: fail");
         $finish;
      end
   end

   // ---------------- sequence
   initial begin
      string s;
      int base, len, n;
      s = "#x!*a **<Ab>||&&::[]";
      foreach (s[i]) add_char(s[i], 1'b0);
      add_char(8'hFF, 1'b1);
      add_char(8'hFF, 1'b0);       // top byte at start: bad char
      s = "#a#";
      foreach (s[i]) add_char(s[i], 1'b0);
      add_char(8'h00, 1'b1);       // tag begun after a token, then end of text
      add_char(8'h00, 1'b0);

      // name closed by end of text
      s = "abcdefgh";
      foreach (s[i]) add_char(s[i], 1'b0);
      add_char(8'h5A, 1'b1);

      base = text_q.size();
      hold_at = base + 300;
      while (text_q.size() < base + RandomChars) begin
         // first group always waits for the queue to run dry
         drain_next = (text_q.size() == base) || ($urandom_range(0, 19) == 0);
         len = $urandom_range(1, 8);
         for (int k = 0; k < len; k++) begin
            case ($urandom_range(0, 15))
               0, 1, 2, 3: begin
                  add_char($urandom_range(0, 9) == 0 ? tft_pkg::ChUnder : rand_letter(),
                           1'b0);
                  n = $urandom_range(0, 6);
                  repeat (n) add_char(rand_word(), 1'b0);
               end
               4, 5: begin
                  add_char(tft_pkg::ChHash, 1'b0);
                  add_char(rand_letter(), 1'b0);
                  n = $urandom_range(0, 5);
                  repeat (n) begin
                     case ($urandom_range(0, 4))
                        0: add_char(tft_pkg::ChDash, 1'b0);
                        1: add_char(tft_pkg::ChDot, 1'b0);
                        default: add_char(rand_word(), 1'b0);
                     endcase
                  end
               end
               6: begin
                  add_char(tft_pkg::ChLt, 1'b0);
                  n = $urandom_range(0, 4);
                  repeat (n) add_char(rand_letter(), 1'b0);
                  add_char(tft_pkg::ChGt, 1'b0);
               end
               7: add_char(tft_pkg::ChBang, 1'b0);
               8: add_char($urandom_range(0, 1) ? tft_pkg::ChLParen : tft_pkg::ChRParen, 1'b0);
               9: add_char($urandom_range(0, 1) ? tft_pkg::ChLBrack : tft_pkg::ChRBrack, 1'b0);
               10: begin
                  if ($urandom_range(0, 1)) begin
                     add_char(tft_pkg::ChBar, 1'b0);
                     add_char(tft_pkg::ChBar, 1'b0);
                  end else begin
                     add_char(tft_pkg::ChAmp, 1'b0);
                     add_char(tft_pkg::ChAmp, 1'b0);
                  end
               end
               11: begin
                  add_char(tft_pkg::ChColon, 1'b0);
                  add_char(tft_pkg::ChColon, 1'b0);
               end
               12: begin
                  add_char(tft_pkg::ChStar, 1'b0);
                  if ($urandom_range(0, 1)) add_char(tft_pkg::ChStar, 1'b0);
               end
               13: add_char(8'($urandom_range(0, 255)), 1'b0);
               14: begin
                  // half of a two-char operator, or an open class
                  case ($urandom_range(0, 3))
                     0: add_char(tft_pkg::ChBar, 1'b0);
                     1: add_char(tft_pkg::ChAmp, 1'b0);
                     2: add_char(tft_pkg::ChColon, 1'b0);
                     default: add_char(tft_pkg::ChLt, 1'b0);
                  endcase
               end
               default: add_char(8'($urandom_range(0, 255)), 1'b1);
            endcase
            if ($urandom_range(0, 3) != 0) begin
               n = $urandom_range(1, 2);
               repeat (n) add_char($urandom_range(0, 1) ? 8'h20 : 8'($urandom_range(9, 13)),
                                   1'b0);
            end
         end
         add_char(8'($urandom_range(0, 255)), 1'b1);
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (text_q.size() > 0 || req_valid) @(posedge clock);
      while (lexeme_q.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/tft_pkg.sv
hdl/tft_lexer.sv
hdl/tft_rsp_fifo.sv
hdl/tag_filter_tokenizer.sv
dv/tag_filter_tokenizer_tb.sv
